@@ rtl/hll_pkg.sv @@
// ----------------------------------------------------------------------------
// hll_pkg
// Shared types, constants and elaboration-time helpers of the HyperLogLog
// cardinality unit.
// ----------------------------------------------------------------------------
package hll_pkg;

  localparam int NUM_REGISTERS_DEF = 1024;
  localparam int INDEX_BITS_DEF    = 10;

  // word actions
  localparam logic ACT_INSERT   = 1'b0;
  localparam logic ACT_ESTIMATE = 1'b1;

  // ln(2) in Q24
  localparam logic [23:0] LN2_Q24 = 24'd11629080;

  // MurmurHash3 x86_32 constants
  localparam logic [31:0] MUR_C1    = 32'hcc9e2d51;
  localparam logic [31:0] MUR_C2    = 32'h1b873593;
  localparam logic [31:0] MUR_ADD   = 32'he6546b64;
  localparam logic [31:0] MUR_LEN   = 32'd4;
  localparam logic [31:0] MUR_FMIX1 = 32'h85ebca6b;
  localparam logic [31:0] MUR_FMIX2 = 32'hc2b2ae35;

  typedef enum logic [2:0] {
    HOP_NONE,
    HOP_KEY,
    HOP_K2,
    HOP_H3,
    HOP_F1,
    HOP_F2
  } hop_t;

  typedef enum logic [1:0] {
    OSEL_E,
    OSEL_MAX,
    OSEL_LN,
    OSEL_LIN
  } osel_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_H2,
    ST_H3,
    ST_F1,
    ST_F2,
    ST_LOOK,
    ST_UPD,
    ST_SCAN,
    ST_SCAN_END,
    ST_DIV,
    ST_DECIDE,
    ST_BRANCH,
    ST_LOG_NORM,
    ST_LOG_SQ,
    ST_LN_MUL,
    ST_LN_SUM,
    ST_LN_DONE,
    ST_LIN_MUL,
    ST_LIN_SUM,
    ST_FIN
  } state_t;

  typedef struct packed {
    hop_t  hop;
    logic  look;
    logic  upd;
    logic  clr_wr;
    logic  scan_rd;
    logic  acc_clr;
    logic  cnt_rst;
    logic  cnt_inc;
    logic  div_init;
    logic  div_step;
    logic  decide;
    logic  log_load;
    logic  log_norm;
    logic  log_init;
    logic  log_sq;
    logic  ln_mul;
    logic  ln_sum;
    logic  lin_mul;
    logic  res_ld;
    osel_t res_sel;
    logic  out_ld;
  } cmd_t;

  typedef struct packed {
    logic cnt_mem_last;
    logic cnt_div_last;
    logic cnt_sq_last;
    logic norm_done;
    logic lin;
    logic big;
    logic sat;
    logic z_zero;
    logic out_busy;
  } stat_t;

  // log2 in Q32 by repeated squaring; used for constants only
  function automatic logic [63:0] log2_q32(input logic [63:0] x);
    int          n;
    logic [63:0] y;
    logic [63:0] frac;
    n    = 0;
    frac = '0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) n = i;
    end
    y = (n >= 31) ? (x >> (n - 31)) : (x << (31 - n));
    for (int i = 0; i < 32; i++) begin
      y    = (y * y) >> 31;
      frac = frac << 1;
      if (y[32]) begin
        y    = y >> 1;
        frac = frac | 64'd1;
      end
    end
    return (64'(n) << 32) | frac;
  endfunction

endpackage

@@ rtl/hll_ctrl.sv @@
// ----------------------------------------------------------------------------
// hll_ctrl
// Sequencer: store clear, insert hashing and update, estimate walk, divide,
// log and correction steps.
// ----------------------------------------------------------------------------
module hll_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_action,
  output logic           in_ready,
  input  hll_pkg::stat_t stat,
  output hll_pkg::cmd_t  cmd
);

  hll_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hll_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      hll_pkg::ST_CLEAR: begin
        cmd.clr_wr  = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (stat.cnt_mem_last) state_nxt = hll_pkg::ST_IDLE;
      end
      hll_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_action == hll_pkg::ACT_ESTIMATE) begin
            cmd.cnt_rst = 1'b1;
            cmd.acc_clr = 1'b1;
            state_nxt   = hll_pkg::ST_SCAN;
          end else begin
            cmd.hop   = hll_pkg::HOP_KEY;
            state_nxt = hll_pkg::ST_H2;
          end
        end
      end
      hll_pkg::ST_H2: begin
        cmd.hop   = hll_pkg::HOP_K2;
        state_nxt = hll_pkg::ST_H3;
      end
      hll_pkg::ST_H3: begin
        cmd.hop   = hll_pkg::HOP_H3;
        state_nxt = hll_pkg::ST_F1;
      end
      hll_pkg::ST_F1: begin
        cmd.hop   = hll_pkg::HOP_F1;
        state_nxt = hll_pkg::ST_F2;
      end
      hll_pkg::ST_F2: begin
        cmd.hop   = hll_pkg::HOP_F2;
        state_nxt = hll_pkg::ST_LOOK;
      end
      hll_pkg::ST_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = hll_pkg::ST_UPD;
      end
      hll_pkg::ST_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = hll_pkg::ST_IDLE;
      end
      hll_pkg::ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (stat.cnt_mem_last) state_nxt = hll_pkg::ST_SCAN_END;
      end
      hll_pkg::ST_SCAN_END: begin
        cmd.div_init = 1'b1;
        cmd.cnt_rst  = 1'b1;
        state_nxt    = hll_pkg::ST_DIV;
      end
      hll_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cmd.cnt_inc  = 1'b1;
        if (stat.cnt_div_last) state_nxt = hll_pkg::ST_DECIDE;
      end
      hll_pkg::ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = hll_pkg::ST_BRANCH;
      end
      hll_pkg::ST_BRANCH: begin
        priority if (stat.lin && !stat.z_zero) begin
          cmd.log_load = 1'b1;
          state_nxt    = hll_pkg::ST_LOG_NORM;
        end else if (stat.lin) begin
          cmd.res_ld  = 1'b1;
          cmd.res_sel = hll_pkg::OSEL_E;
          state_nxt   = hll_pkg::ST_FIN;
        end else if (stat.big && stat.sat) begin
          cmd.res_ld  = 1'b1;
          cmd.res_sel = hll_pkg::OSEL_MAX;
          state_nxt   = hll_pkg::ST_FIN;
        end else if (stat.big) begin
          cmd.log_load = 1'b1;
          state_nxt    = hll_pkg::ST_LOG_NORM;
        end else begin
          cmd.res_ld  = 1'b1;
          cmd.res_sel = hll_pkg::OSEL_E;
          state_nxt   = hll_pkg::ST_FIN;
        end
      end
      hll_pkg::ST_LOG_NORM: begin
        if (stat.norm_done) begin
          cmd.log_init = 1'b1;
          cmd.cnt_rst  = 1'b1;
          state_nxt    = hll_pkg::ST_LOG_SQ;
        end else begin
          cmd.log_norm = 1'b1;
        end
      end
      hll_pkg::ST_LOG_SQ: begin
        cmd.log_sq  = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (stat.cnt_sq_last) state_nxt = hll_pkg::ST_LN_MUL;
      end
      hll_pkg::ST_LN_MUL: begin
        cmd.ln_mul = 1'b1;
        state_nxt  = hll_pkg::ST_LN_SUM;
      end
      hll_pkg::ST_LN_SUM: begin
        cmd.ln_sum = 1'b1;
        state_nxt  = hll_pkg::ST_LN_DONE;
      end
      hll_pkg::ST_LN_DONE: begin
        if (stat.lin) begin
          state_nxt = hll_pkg::ST_LIN_MUL;
        end else begin
          cmd.res_ld  = 1'b1;
          cmd.res_sel = hll_pkg::OSEL_LN;
          state_nxt   = hll_pkg::ST_FIN;
        end
      end
      hll_pkg::ST_LIN_MUL: begin
        cmd.lin_mul = 1'b1;
        state_nxt   = hll_pkg::ST_LIN_SUM;
      end
      hll_pkg::ST_LIN_SUM: begin
        cmd.res_ld  = 1'b1;
        cmd.res_sel = hll_pkg::OSEL_LIN;
        state_nxt   = hll_pkg::ST_FIN;
      end
      hll_pkg::ST_FIN: begin
        if (!stat.out_busy) begin
          cmd.out_ld = 1'b1;
          state_nxt  = hll_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = hll_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/hll_dp.sv @@
// ----------------------------------------------------------------------------
// hll_dp
// Datapath: hash, rank store, harmonic sum, divider, log unit and
// correction arithmetic, result register.
// ----------------------------------------------------------------------------
module hll_dp #(
  parameter int NUM_REGISTERS = hll_pkg::NUM_REGISTERS_DEF,
  parameter int INDEX_BITS    = hll_pkg::INDEX_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  hll_pkg::cmd_t cmd,
  output hll_pkg::stat_t stat,
  input  logic [31:0]   in_flow_id,
  input  logic          cfg_wr_en,
  input  logic [31:0]   cfg_wr_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   out_cardinality
);

  localparam int AW = $clog2(NUM_REGISTERS);
  localparam int CW = (AW > 6) ? AW : 6;
  localparam int W  = 32 - INDEX_BITS;
  localparam int SW = AW + 33;
  localparam int MW = AW + 1;
  localparam int XW = ((INDEX_BITS > AW) ? INDEX_BITS : AW) + 1;

  localparam logic [63:0] M64   = 64'(NUM_REGISTERS);
  localparam logic [63:0] BASE  = (64'd7213 << 32) / 64'd10000;
  localparam logic [63:0] ALPHA =
    (NUM_REGISTERS == 16) ? (64'd673 << 32) / 64'd1000 :
    (NUM_REGISTERS == 32) ? (64'd697 << 32) / 64'd1000 :
    (NUM_REGISTERS == 64) ? (64'd709 << 32) / 64'd1000 :
    BASE * (64'd1000 * M64) / (64'd1000 * M64 + 64'd1079);
  localparam logic [63:0] NUMER  = ALPHA * M64 * M64;
  localparam logic [63:0] L2M    = hll_pkg::log2_q32(M64);
  localparam logic [64:0] FIVE_M = 65'(M64) * 65'd5;
  localparam logic [MW-1:0] M_W  = MW'(NUM_REGISTERS);

  // configuration
  logic [31:0] seed_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_wr_en) begin
      seed_r <= cfg_wr_data;
    end
  end

  // hash sequencer register
  logic [31:0] hv_r, hv_nxt, ht_a, ht_b;
  always_comb begin
    hv_nxt = hv_r;
    ht_a   = '0;
    ht_b   = '0;
    unique case (cmd.hop)
      hll_pkg::HOP_NONE: hv_nxt = hv_r;
      hll_pkg::HOP_KEY:  hv_nxt = in_flow_id * hll_pkg::MUR_C1;
      hll_pkg::HOP_K2:   hv_nxt = {hv_r[16:0], hv_r[31:17]} * hll_pkg::MUR_C2;
      hll_pkg::HOP_H3: begin
        ht_a   = seed_r ^ hv_r;
        hv_nxt = {ht_a[18:0], ht_a[31:19]} * 32'd5 + hll_pkg::MUR_ADD;
      end
      hll_pkg::HOP_F1: begin
        ht_a   = hv_r ^ hll_pkg::MUR_LEN;
        ht_b   = ht_a ^ (ht_a >> 16);
        hv_nxt = ht_b * hll_pkg::MUR_FMIX1;
      end
      hll_pkg::HOP_F2: begin
        ht_a   = hv_r ^ (hv_r >> 13);
        hv_nxt = ht_a * hll_pkg::MUR_FMIX2;
      end
      default: hv_nxt = hv_r;
    endcase
  end

  always_ff @(posedge clk) begin
    hv_r <= hv_nxt;
  end

  // index and rank of the finished hash
  logic [31:0]   h_fin;
  logic [XW-1:0] top_c;
  logic [AW-1:0] idx_c, idx_r;
  logic [W-1:0]  q_c;
  logic [5:0]    len_c;
  logic [5:0]    rank6_c;
  logic [4:0]    rank_r;
  always_comb begin
    h_fin = hv_r ^ (hv_r >> 16);
    top_c = XW'(h_fin[31:W]);
    if (top_c >= XW'(NUM_REGISTERS)) top_c = top_c - XW'(NUM_REGISTERS);
    idx_c = top_c[AW-1:0];
    q_c   = h_fin[W-1:0];
    len_c = '0;
    for (int i = 0; i < W; i++) begin
      if (q_c[i]) len_c = 6'(i + 1);
    end
    rank6_c = 6'(W) - len_c + 6'd1;
  end

  always_ff @(posedge clk) begin
    if (cmd.look) begin
      idx_r  <= idx_c;
      rank_r <= rank6_c[4:0];
    end
  end

  // walk counter
  logic [CW-1:0] cnt_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_rst) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + CW'(1);
    end
  end

  // rank store
  logic [4:0]    mem [NUM_REGISTERS];
  logic [4:0]    rd_q_r;
  logic          mem_we, mem_re;
  logic [AW-1:0] waddr, raddr;
  logic [4:0]    wdata;
  always_comb begin
    mem_we = cmd.clr_wr | (cmd.upd & (rank_r > rd_q_r));
    waddr  = cmd.clr_wr ? cnt_r[AW-1:0] : idx_r;
    wdata  = cmd.clr_wr ? 5'd0 : rank_r;
    mem_re = cmd.look | cmd.scan_rd;
    raddr  = cmd.look ? idx_c : cnt_r[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    if (mem_re) rd_q_r <= mem[raddr];
  end

  // harmonic sum and zero count
  logic          scan_vld_r;
  logic [SW-1:0] s_r;
  logic [MW-1:0] z_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_vld_r <= 1'b0;
    end else begin
      scan_vld_r <= cmd.scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      s_r <= '0;
      z_r <= '0;
    end else if (scan_vld_r) begin
      s_r <= s_r + (SW'(1) << (6'd32 - {1'b0, rd_q_r}));
      if (rd_q_r == 5'd0) z_r <= z_r + MW'(1);
    end
  end

  // restoring divider, one quotient bit a cycle
  logic [SW-1:0] rem_r;
  logic [SW:0]   rem_sh;
  logic [63:0]   e_r;
  logic          nb;
  always_comb begin
    nb     = NUMER[6'd63 - cnt_r[5:0]];
    rem_sh = {rem_r, nb};
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r <= '0;
      e_r   <= '0;
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, s_r}) begin
        rem_r <= SW'(rem_sh - {1'b0, s_r});
        e_r   <= {e_r[62:0], 1'b1};
      end else begin
        rem_r <= rem_sh[SW-1:0];
        e_r   <= {e_r[62:0], 1'b0};
      end
    end
  end

  // range decision
  logic        lin_r, big_r, sat_r;
  logic [68:0] thirty_e;
  always_comb begin
    thirty_e = {e_r, 5'b0} - {4'b0, e_r, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      lin_r <= {e_r, 1'b0} <= FIVE_M;
      big_r <= thirty_e > 69'h1_0000_0000;
      sat_r <= e_r[63:32] != 32'd0;
    end
  end

  // log2 unit: normalise one bit a cycle, then 32 squarings
  logic [32:0] x_r;
  logic [5:0]  n_r;
  logic [31:0] y_r, frac_r;
  logic [63:0] sq;
  logic [32:0] sq_t;
  always_comb begin
    sq   = 64'(y_r) * 64'(y_r);
    sq_t = sq[63:31];
  end

  always_ff @(posedge clk) begin
    if (cmd.log_load) begin
      x_r <= lin_r ? 33'(z_r) : 33'h1_0000_0000 - e_r[32:0];
      n_r <= 6'd32;
    end else if (cmd.log_norm) begin
      x_r <= {x_r[31:0], 1'b0};
      n_r <= n_r - 6'd1;
    end
    if (cmd.log_init) begin
      y_r    <= x_r[32:1];
      frac_r <= '0;
    end else if (cmd.log_sq) begin
      if (sq_t[32]) begin
        y_r    <= sq_t[32:1];
        frac_r <= {frac_r[30:0], 1'b1};
      end else begin
        y_r    <= sq_t[31:0];
        frac_r <= {frac_r[30:0], 1'b0};
      end
    end
  end

  // natural log in Q32 from the log2 difference
  logic [37:0] lg, l_c;
  logic [55:0] pa_r;
  logic [29:0] pb_r;
  logic [38:0] ln_r;
  always_comb begin
    lg  = {n_r, frac_r};
    l_c = lin_r ? (L2M[37:0] - lg) : ({6'd32, 32'd0} - lg);
  end

  always_ff @(posedge clk) begin
    if (cmd.ln_mul) begin
      pa_r <= 56'(l_c[31:0]) * 56'(hll_pkg::LN2_Q24);
      pb_r <= 30'(l_c[37:32]) * 30'(hll_pkg::LN2_Q24);
    end
    if (cmd.ln_sum) begin
      ln_r <= 39'({pb_r, 8'b0}) + 39'(pa_r[55:24]);
    end
  end

  // linear counting: m * ln >> 32, split at bit 32; always below 2^32
  logic [MW+31:0] pl_r;
  logic [MW+6:0]  ph_r;
  logic [MW+7:0]  lin_val;
  always_comb begin
    lin_val = (MW+8)'(ph_r) + (MW+8)'(pl_r[MW+31:32]);
  end

  always_ff @(posedge clk) begin
    if (cmd.lin_mul) begin
      pl_r <= (MW+32)'(M_W) * (MW+32)'(ln_r[31:0]);
      ph_r <= (MW+7)'(M_W) * (MW+7)'(ln_r[38:32]);
    end
  end

  // result selection with saturation
  logic [31:0] res_r, res_c;
  always_comb begin
    unique case (cmd.res_sel)
      hll_pkg::OSEL_E:   res_c = (e_r[63:32] != '0) ? '1 : e_r[31:0];
      hll_pkg::OSEL_MAX: res_c = '1;
      hll_pkg::OSEL_LN:  res_c = (ln_r[38:32] != '0) ? '1 : ln_r[31:0];
      hll_pkg::OSEL_LIN: res_c = 32'(lin_val);
      default:           res_c = '1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_ld) res_r <= res_c;
  end

  // output word register
  logic        out_valid_r;
  logic [31:0] out_card_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) out_card_r <= res_r;
  end

  assign out_valid       = out_valid_r;
  assign out_cardinality = out_card_r;

  always_comb begin
    stat.cnt_mem_last = cnt_r == CW'(NUM_REGISTERS - 1);
    stat.cnt_div_last = cnt_r == CW'(63);
    stat.cnt_sq_last  = cnt_r == CW'(31);
    stat.norm_done    = x_r[32];
    stat.lin          = lin_r;
    stat.big          = big_r;
    stat.sat          = sat_r;
    stat.z_zero       = z_r == '0;
    stat.out_busy     = out_valid_r & ~out_ready;
  end

`ifndef SYNTHESIS
  a_upd_idx: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd |-> (32'(idx_r) < 32'(NUM_REGISTERS)))
    else $error("rank update index beyond store");
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (rem_r < s_r))
    else $error("divider remainder not below divisor");
  a_log_norm: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.log_sq |-> y_r[31])
    else $error("log mantissa lost normalisation");
`endif

endmodule

@@ rtl/hyperloglog_cardinality_unit.sv @@
// Insert word: accepted in idle; the next word is taken once the insert is done
//   (5 hash steps, rank read, rank write).
// Estimate word: next word taken after the store walk, the 64-step divider and, for a
//   log correction, normalise and squarings, once the output register is free.
// Reset: synchronous active low; a clearing pass over all NUM_REGISTERS entries then
//   zeroes the rank store, during which no word is accepted.
// ----------------------------------------------------------------------------
// hyperloglog_cardinality_unit
// HyperLogLog distinct-count unit: inserts update a rank store, estimates
// return the corrected harmonic estimate.
// ----------------------------------------------------------------------------
module hyperloglog_cardinality_unit #(
  parameter int NUM_REGISTERS = hll_pkg::NUM_REGISTERS_DEF,
  parameter int INDEX_BITS    = hll_pkg::INDEX_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [31:0] in_flow_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_cardinality,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  // Control and datapath talk only through the command and status bundles.
  hll_pkg::cmd_t  cmd;
  hll_pkg::stat_t stat;

  // Sequencer: holds the state machine, owns in_ready (idle only).
  hll_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_ready  (in_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: hash, rank store, sum, divider, log unit and result word.
  // The output word register lets the next word be taken while a result waits.
  hll_dp #(
    .NUM_REGISTERS (NUM_REGISTERS),
    .INDEX_BITS    (INDEX_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_flow_id      (in_flow_id),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_cardinality (out_cardinality)
  );

endmodule
